[rtl/core/pbpt_pkg.sv]
// Shared types and constants for the pointer button press tracker.
package pbpt_pkg;

   localparam int TABLE_SIZE = 16;
   localparam int IDX_W      = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
   localparam int CNT_W      = $clog2(TABLE_SIZE + 1);
   localparam int CODE_W     = 16;
   localparam int PRESS_W    = 16;
   localparam int OP_W       = 2;
   localparam int STATUS_W   = 3;
   localparam int HELD_OUT_W = 5;

   localparam logic [PRESS_W-1:0] PRESS_MAX = '1;

   // Operation codes on the request side; any code other than press or clear
   // is handled as a release.
   localparam logic [OP_W-1:0] OP_RELEASE = 2'd0;
   localparam logic [OP_W-1:0] OP_PRESS   = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR   = 2'd2;

   typedef enum logic [STATUS_W-1:0] {
      ST_FORWARD = 3'd0,
      ST_REPEAT  = 3'd1,
      ST_FULL    = 3'd2,
      ST_UNKNOWN = 3'd3,
      ST_HELD    = 3'd4,
      ST_CLEARED = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_SCAN,
      FSM_MOVE,
      FSM_DONE
   } fsm_type;

   typedef struct packed {
      logic [CODE_W-1:0]  code;
      logic [PRESS_W-1:0] presses;
   } entry_type;

   typedef struct packed {
      status_type            status;
      logic                  sole;
      logic [CODE_W-1:0]     grab;
      logic [HELD_OUT_W-1:0] held_count;
   } result_type;

endpackage

[rtl/core/pointer_button_press_tracker.sv]
// Top level of the pointer button press tracker: stream ports and result register.
//
//   Channel   Dir   Beat contents
//   req_*     in    tuser: operation; tdata: button_code
//   rsp_*     out   tdata: status, forward_event, sole press, grab_key, held_count
//
// A clear goes straight to the result state. A press or release walks the held
// entries in the table memory, one read a cycle, until a hit or all are read; a
// removal from a slot other than the last refills it from the last entry in a
// move step. One item is in work.
// The output register holds a result while rsp_tready is low; the input then stalls.
// Reset empties the table and clears the grab key; no clearing pass is run.
module pointer_button_press_tracker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,  // [15:0] button_code
   input  logic [1:0]  req_tuser,  // [1:0] operation
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata   // [2:0] status, [3] forward_event,
                                   // [4] sole_button_press, [20:5] grab_key,
                                   // [25:21] held_count, [31:26] zero
);

   logic                 res_valid;
   logic                 res_ready;
   pbpt_pkg::result_type res;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [31:0]          rsp_data_ff, rsp_data_in;

   pbpt_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .start_valid (req_tvalid),
      .start_ready (req_tready),
      .start_op    (req_tuser),
      .start_code  (req_tdata),
      .res_valid   (res_valid),
      .res_ready   (res_ready),
      .res         (res)
   );

   // Take a new result when the output register is empty or draining this cycle.
   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {6'd0,
                         res.held_count,
                         res.grab,
                         res.sole,
                         (res.status == pbpt_pkg::ST_FORWARD),
                         res.status};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

[rtl/core/pbpt_engine.sv]
// Table memory and scan sequencer of the pointer button press tracker.
module pbpt_engine (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start_valid,
   output logic                         start_ready,
   input  logic [pbpt_pkg::OP_W-1:0]    start_op,
   input  logic [pbpt_pkg::CODE_W-1:0]  start_code,
   output logic                         res_valid,
   input  logic                         res_ready,
   output pbpt_pkg::result_type         res
);

   pbpt_pkg::entry_type entry_mem [pbpt_pkg::TABLE_SIZE];

   pbpt_pkg::fsm_type               state_ff, state_in;
   logic [pbpt_pkg::OP_W-1:0]       op_ff, op_in;
   logic [pbpt_pkg::CODE_W-1:0]     code_ff, code_in;
   logic [pbpt_pkg::CODE_W-1:0]     grab_ff, grab_in;
   logic [pbpt_pkg::CNT_W-1:0]      held_ff, held_in;
   logic [pbpt_pkg::CNT_W-1:0]      issue_ff, issue_in;
   logic                            pend_ff, pend_in;
   logic [pbpt_pkg::IDX_W-1:0]      pend_addr_ff, pend_addr_in;
   logic [pbpt_pkg::IDX_W-1:0]      hit_addr_ff, hit_addr_in;
   pbpt_pkg::status_type            status_ff, status_in;
   logic                            sole_ff, sole_in;
   pbpt_pkg::entry_type             rd_data_ff;

   logic                            rd_en;
   logic [pbpt_pkg::IDX_W-1:0]      rd_addr;
   logic                            wr_en;
   logic [pbpt_pkg::IDX_W-1:0]      wr_addr;
   pbpt_pkg::entry_type             wr_data;

   logic                            is_press;
   logic                            hit;
   logic                            exhausted;
   logic [pbpt_pkg::CNT_W-1:0]      held_dec;
   logic [pbpt_pkg::IDX_W-1:0]      last_idx;
   logic [pbpt_pkg::PRESS_W-1:0]    press_dec;
   logic                            remove_moves;

   assign is_press  = (op_ff == pbpt_pkg::OP_PRESS);
   assign hit       = pend_ff && (rd_data_ff.code == code_ff);
   assign exhausted = !pend_ff && (issue_ff >= held_ff);
   assign held_dec  = held_ff - pbpt_pkg::CNT_W'(1);
   assign last_idx  = held_dec[pbpt_pkg::IDX_W-1:0];
   assign press_dec = rd_data_ff.presses - pbpt_pkg::PRESS_W'(1);
   // Release that empties a slot other than the last one: pull the last entry in.
   assign remove_moves = !is_press && (press_dec == '0) && (pend_addr_ff != last_idx);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pbpt_pkg::FSM_IDLE: begin
            if (start_valid) begin
               state_in = (start_op == pbpt_pkg::OP_CLEAR) ? pbpt_pkg::FSM_DONE
                                                           : pbpt_pkg::FSM_SCAN;
            end
         end
         pbpt_pkg::FSM_SCAN: begin
            if (hit) begin
               state_in = remove_moves ? pbpt_pkg::FSM_MOVE : pbpt_pkg::FSM_DONE;
            end else if (exhausted) begin
               state_in = pbpt_pkg::FSM_DONE;
            end
         end
         pbpt_pkg::FSM_MOVE: begin
            state_in = pbpt_pkg::FSM_DONE;
         end
         pbpt_pkg::FSM_DONE: begin
            if (res_ready) begin
               state_in = pbpt_pkg::FSM_IDLE;
            end
         end
         default: begin
            state_in = pbpt_pkg::FSM_IDLE;
         end
      endcase
   end

   // Datapath and memory controls
   always_comb begin
      op_in        = op_ff;
      code_in      = code_ff;
      grab_in      = grab_ff;
      held_in      = held_ff;
      issue_in     = issue_ff;
      pend_in      = 1'b0;
      pend_addr_in = pend_addr_ff;
      hit_addr_in  = hit_addr_ff;
      status_in    = status_ff;
      sole_in      = sole_ff;
      rd_en        = 1'b0;
      rd_addr      = issue_ff[pbpt_pkg::IDX_W-1:0];
      wr_en        = 1'b0;
      wr_addr      = pend_addr_ff;
      wr_data      = rd_data_ff;
      start_ready  = 1'b0;
      res_valid    = 1'b0;
      case (state_ff)
         pbpt_pkg::FSM_IDLE: begin
            start_ready = 1'b1;
            if (start_valid) begin
               op_in     = start_op;
               code_in   = start_code;
               issue_in  = '0;
               sole_in   = 1'b0;
               if (start_op == pbpt_pkg::OP_CLEAR) begin
                  held_in   = '0;
                  status_in = pbpt_pkg::ST_CLEARED;
               end else if (start_op == pbpt_pkg::OP_PRESS && held_ff == '0) begin
                  grab_in = start_code;
               end
            end
         end
         pbpt_pkg::FSM_SCAN: begin
            // Issue the next read while the previous one is compared.
            if (!hit && issue_ff < held_ff) begin
               rd_en        = 1'b1;
               rd_addr      = issue_ff[pbpt_pkg::IDX_W-1:0];
               issue_in     = issue_ff + pbpt_pkg::CNT_W'(1);
               pend_in      = 1'b1;
               pend_addr_in = issue_ff[pbpt_pkg::IDX_W-1:0];
            end
            if (hit) begin
               if (is_press) begin
                  wr_en        = 1'b1;
                  wr_data.code = code_ff;
                  wr_data.presses = (rd_data_ff.presses == pbpt_pkg::PRESS_MAX)
                                  ? rd_data_ff.presses
                                  : rd_data_ff.presses + pbpt_pkg::PRESS_W'(1);
                  status_in    = pbpt_pkg::ST_REPEAT;
               end else if (press_dec != '0) begin
                  wr_en           = 1'b1;
                  wr_data.code    = code_ff;
                  wr_data.presses = press_dec;
                  status_in       = pbpt_pkg::ST_HELD;
               end else begin
                  held_in   = held_dec;
                  status_in = pbpt_pkg::ST_FORWARD;
                  if (remove_moves) begin
                     rd_en       = 1'b1;
                     rd_addr     = last_idx;
                     hit_addr_in = pend_addr_ff;
                  end
               end
            end else if (exhausted) begin
               if (!is_press) begin
                  status_in = pbpt_pkg::ST_UNKNOWN;
               end else if (held_ff >= pbpt_pkg::CNT_W'(pbpt_pkg::TABLE_SIZE)) begin
                  status_in = pbpt_pkg::ST_FULL;
               end else begin
                  wr_en           = 1'b1;
                  wr_addr         = held_ff[pbpt_pkg::IDX_W-1:0];
                  wr_data.code    = code_ff;
                  wr_data.presses = pbpt_pkg::PRESS_W'(1);
                  held_in         = held_ff + pbpt_pkg::CNT_W'(1);
                  status_in       = pbpt_pkg::ST_FORWARD;
                  sole_in         = (held_ff == '0);
               end
            end
         end
         pbpt_pkg::FSM_MOVE: begin
            // Last entry arrived from memory: drop it into the freed slot.
            wr_en   = 1'b1;
            wr_addr = hit_addr_ff;
            wr_data = rd_data_ff;
         end
         pbpt_pkg::FSM_DONE: begin
            res_valid = 1'b1;
         end
         default: begin
            res_valid = 1'b0;
         end
      endcase
   end

   assign res.status     = status_ff;
   assign res.sole       = sole_ff;
   assign res.grab       = grab_ff;
   assign res.held_count = pbpt_pkg::HELD_OUT_W'(held_ff);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= entry_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pbpt_pkg::FSM_IDLE;
         held_ff  <= '0;
         grab_ff  <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         held_ff  <= held_in;
         grab_ff  <= grab_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      code_ff      <= code_in;
      issue_ff     <= issue_in;
      pend_addr_ff <= pend_addr_in;
      hit_addr_ff  <= hit_addr_in;
      status_ff    <= status_in;
      sole_ff      <= sole_in;
   end

endmodule

[rtl/core/pbpt_checker.sv]
// Port-level assertions for the pointer button press tracker, bound to the top level.
module pbpt_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [15:0] req_tdata,
   input logic [1:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata
);

   logic [2:0] status;
   logic [4:0] held;

   assign status = rsp_tdata[2:0];
   assign held   = rsp_tdata[25:21];

   // Hold a stalled result beat.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result beat changed");

   a_forward_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[3] == (status == pbpt_pkg::ST_FORWARD))
      else $error("forward flag disagrees with status");

   a_sole_press: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[4] |-> rsp_tdata[3] && held == 5'd1)
      else $error("sole press without exactly one held button");

   a_cleared_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && status == pbpt_pkg::ST_CLEARED |-> held == 5'd0)
      else $error("clear left buttons held");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && status == pbpt_pkg::ST_FULL |-> held == 5'(pbpt_pkg::TABLE_SIZE))
      else $error("table full reported below capacity");

endmodule

bind pointer_button_press_tracker pbpt_checker u_pbpt_checker (.*);
